FILE: src/tse_pkg.sv
package tse_pkg;

   // text codes
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'd32;

   // explicit stop list limit (1 to 8)
   localparam int unsigned MAX_STOPS = 4;

   localparam logic [15:0] COL_MAX   = 16'hFFFF;
   localparam logic [6:0]  WIDTH_MAX = 7'd64;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 7;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STOP_COUNT    = 3'd0,
      REG_STOP_WIDTH_A  = 3'd1,
      REG_STOP_WIDTH_B  = 3'd2,
      REG_STOP_WIDTH_C  = 3'd3,
      REG_STOP_WIDTH_D  = 3'd4,
      REG_DEFAULT_WIDTH = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SPACE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // take input byte, advance stop if reached
      logic tab_setup;   // latch space count for a tab
      logic emit_char;   // pass held byte to output register
      logic emit_space;  // put one space in output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tab;
      logic tab_zero;    // tab yields no spaces
      logic slot_free;   // output register can take a new item
      logic last_space;  // one space left
   } status_type;

endpackage

FILE: src/tse_ctrl.sv
module tse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tse_pkg::status_type status,
   output tse_pkg::cmd_type    cmd
);
   import tse_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_tab) begin
               state_in = status.tab_zero ? ST_IDLE : ST_SPACE;
            end else if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SPACE: begin
            if (status.slot_free && status.last_space) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_DECODE: begin
            cmd.tab_setup = status.is_tab;
            cmd.emit_char = !status.is_tab && status.slot_free;
         end
         ST_SPACE: begin
            cmd.emit_space = status.slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

FILE: src/tse_datapath.sv
module tse_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [tse_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tse_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [7:0]                         req_in_byte,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_last,
   input  tse_pkg::cmd_type                   cmd,
   output tse_pkg::status_type                status
);
   import tse_pkg::*;

   function automatic logic [6:0] clamp_width(input logic [6:0] w);
      logic [6:0] r;
      if (w == 7'd0) begin
         r = 7'd1;
      end else if (w > WIDTH_MAX) begin
         r = WIDTH_MAX;
      end else begin
         r = w;
      end
      return r;
   endfunction

   // configuration registers
   logic [2:0] stop_count_ff;
   logic [6:0] stop_width_a_ff, stop_width_b_ff, stop_width_c_ff, stop_width_d_ff;
   logic [6:0] default_width_ff;

   // tracking state
   logic [15:0] column_ff, column_in;
   logic [15:0] next_stop_ff, next_stop_in;
   logic [2:0]  stop_index_ff, stop_index_in;
   logic [7:0]  byte_ff, byte_in;
   logic [6:0]  count_ff, count_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       last_ff, last_in;

   logic [3:0]  limit;
   logic [6:0]  raw_width;
   logic [16:0] stop_sum;
   logic [16:0] stop_diff;
   logic [6:0]  space_n;
   logic [15:0] column_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff    <= 3'd0;
         stop_width_a_ff  <= 7'd4;
         stop_width_b_ff  <= 7'd4;
         stop_width_c_ff  <= 7'd4;
         stop_width_d_ff  <= 7'd4;
         default_width_ff <= 7'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_STOP_COUNT:    stop_count_ff    <= csr_wdata[2:0];
            REG_STOP_WIDTH_A:  stop_width_a_ff  <= csr_wdata;
            REG_STOP_WIDTH_B:  stop_width_b_ff  <= csr_wdata;
            REG_STOP_WIDTH_C:  stop_width_c_ff  <= csr_wdata;
            REG_STOP_WIDTH_D:  stop_width_d_ff  <= csr_wdata;
            REG_DEFAULT_WIDTH: default_width_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stop advance
   always_comb begin
      limit = ({1'b0, stop_count_ff} > 4'(MAX_STOPS)) ? 4'(MAX_STOPS)
                                                      : {1'b0, stop_count_ff};
      if ({1'b0, stop_index_ff} < limit) begin
         unique case (stop_index_ff)
            3'd0:    raw_width = stop_width_a_ff;
            3'd1:    raw_width = stop_width_b_ff;
            3'd2:    raw_width = stop_width_c_ff;
            3'd3:    raw_width = stop_width_d_ff;
            default: raw_width = default_width_ff;
         endcase
      end else begin
         raw_width = default_width_ff;
      end
      stop_sum = {1'b0, next_stop_ff} + {10'd0, clamp_width(raw_width)};
   end

   // spaces to the stop
   always_comb begin
      stop_diff = {1'b0, next_stop_ff} - {1'b0, column_ff};
      if (next_stop_ff <= column_ff) begin
         space_n = 7'd0;
      end else if (stop_diff > {10'd0, WIDTH_MAX}) begin
         space_n = WIDTH_MAX;
      end else begin
         space_n = stop_diff[6:0];
      end
      column_inc = (column_ff == COL_MAX) ? COL_MAX : column_ff + 16'd1;
   end

   always_comb begin
      column_in     = column_ff;
      next_stop_in  = next_stop_ff;
      stop_index_in = stop_index_ff;
      byte_in       = byte_ff;
      count_in      = count_ff;
      out_byte_in   = out_byte_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         byte_in = req_in_byte;
         if (column_ff >= next_stop_ff) begin
            next_stop_in = stop_sum[16] ? COL_MAX : stop_sum[15:0];
            if ({1'b0, stop_index_ff} < limit) begin
               stop_index_in = stop_index_ff + 3'd1;
            end
         end
      end

      if (cmd.tab_setup) begin
         count_in = space_n;
      end

      if (cmd.emit_char) begin
         out_byte_in  = byte_ff;
         last_in      = 1'b1;
         rsp_valid_in = 1'b1;
         if (byte_ff == CH_NL) begin
            column_in     = 16'd0;
            next_stop_in  = 16'd0;
            stop_index_in = 3'd0;
         end else begin
            column_in = column_inc;
         end
      end

      if (cmd.emit_space) begin
         out_byte_in  = CH_SPACE;
         last_in      = (count_ff == 7'd1);
         rsp_valid_in = 1'b1;
         count_in     = count_ff - 7'd1;
         column_in    = column_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= 16'd0;
         next_stop_ff  <= 16'd0;
         stop_index_ff <= 3'd0;
         count_ff      <= 7'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         column_ff     <= column_in;
         next_stop_ff  <= next_stop_in;
         stop_index_ff <= stop_index_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
   end

   assign status.is_tab     = (byte_ff == CH_TAB);
   assign status.tab_zero   = (space_n == 7'd0);
   assign status.slot_free  = !rsp_valid_ff || !rsp_stall;
   assign status.last_space = (count_ff == 7'd1);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = last_ff;

endmodule

FILE: src/tab_stop_expander.sv
// flow: an item is taken in the idle state and held; in the decode state a plain byte or
//   newline goes to the single output register once it has room, while a tab loads the
//   space counter and the space state then puts its n spaces (n up to 64) into that register
//   as room comes; a new item is taken only once the last one is through
// reset: synchronous, active high; clears column, stop and stop index, empties the
//   output register and loads the configuration registers with their reset values
module tab_stop_expander (
   input  logic                           clock,
   input  logic                           reset,
   // configuration write port
   input  logic                           csr_we,
   input  logic [tse_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tse_pkg::CSR_DATA_W-1:0] csr_wdata,
   // input text bytes
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_in_byte,
   // expanded text bytes
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_last
);
   import tse_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: idle -> decode -> (spaces for a tab)
   tse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // column tracking, stop list, space counter and output register
   tse_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_in_byte  (req_in_byte),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

FILE: verif/tb_tab_stop_expander.sv
module tb_tab_stop_expander;
   import tse_pkg::*;

   // run shape
   localparam int unsigned RANDOM_ITEMS    = 187;   // random items after the directed table
   localparam int unsigned SETTLE_CYCLES   = 8;     // block latency plus a margin
   localparam int unsigned PRESSURE_CYCLES = 300;   // one long receiver hold-off
   localparam int unsigned WATCHDOG_LIMIT  = 2000;  // cycles with no handshake or register write
   localparam int unsigned REPORT_CAP      = 100;   // cap the log on a broken build

   // one expected output item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } text_result_type;

   // directed plan: register writes and text items, some with typed expectations
   typedef enum logic {ROW_REG, ROW_TEXT} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      reg_index_type idx;
      logic [6:0]    value;
      logic [7:0]    text;
      logic          typed;
      logic [7:0]    want_byte;
      logic [6:0]    want_n;
   } plan_row_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_in_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last;

   // expected output items, oldest first
   text_result_type due_text[$];
   int unsigned     fail_count   = 0;
   int unsigned     quiet_cycles = 0;
   bit              pressure_go  = 1'b0;

   // predictor copy of the configuration, reset values
   logic [2:0] cfg_count   = 3'd0;
   logic [6:0] cfg_width [0:3] = '{7'd4, 7'd4, 7'd4, 7'd4};
   logic [6:0] cfg_default = 7'd4;

   // predictor copy of the line state
   logic [15:0] line_col  = '0;
   logic [15:0] line_stop = '0;
   logic [2:0]  list_pos  = '0;

   plan_row_type script[$];

   tab_stop_expander dut (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   always #1 clock = ~clock;

   // column arithmetic pins at the top of the 16-bit range
   function automatic logic [15:0] sat_col(input logic [15:0] a, input int unsigned d);
      int unsigned s;
      s = a + d;
      return (s > COL_MAX) ? COL_MAX : s[15:0];
   endfunction

   // advance the line state by one input byte; returns how many items it gives,
   // all carrying the byte in ob
   function automatic int unsigned expand_byte(input logic [7:0] b, output logic [7:0] ob);
      int unsigned limit;
      int unsigned n;
      logic [6:0]  w;
      limit = cfg_count;
      if (limit > MAX_STOPS) limit = MAX_STOPS;
      // stop reached: step to the next listed width, then the default one
      if (line_col >= line_stop) begin
         if (list_pos < limit) begin
            w = cfg_width[list_pos[1:0]];
            list_pos = list_pos + 3'd1;
         end else begin
            w = cfg_default;
         end
         if (w == 7'd0) w = 7'd1;
         else if (w > WIDTH_MAX) w = WIDTH_MAX;
         line_stop = sat_col(line_stop, w);
      end
      if (b == CH_TAB) begin
         // spaces up to the stop, none once column and stop are both pinned
         n = (line_stop > line_col) ? 32'(line_stop - line_col) : 0;
         if (n > WIDTH_MAX) n = 32'(WIDTH_MAX);
         line_col = sat_col(line_col, n);
         ob = CH_SPACE;
      end else begin
         n = 1;
         ob = b;
         if (b == CH_NL) begin
            // newline throws away any stop advance just made
            line_col  = '0;
            line_stop = '0;
            list_pos  = '0;
         end else begin
            line_col = sat_col(line_col, 1);
         end
      end
      return n;
   endfunction

   function automatic void queue_results(input logic [7:0] b, input int unsigned n);
      for (int unsigned i = 0; i < n; i++) due_text.push_back('{b, (i + 1 == n)});
   endfunction

   function automatic plan_row_type reg_row(input reg_index_type idx, input logic [6:0] v);
      return '{ROW_REG, idx, v, 8'd0, 1'b0, 8'd0, 7'd0};
   endfunction

   function automatic plan_row_type byte_row(input logic [7:0] b);
      return '{ROW_TEXT, REG_STOP_COUNT, 7'd0, b, 1'b0, 8'd0, 7'd0};
   endfunction

   function automatic plan_row_type known_row(input logic [7:0] b, input logic [7:0] wb,
                                              input logic [6:0] wn);
      return '{ROW_TEXT, REG_STOP_COUNT, 7'd0, b, 1'b1, wb, wn};
   endfunction

   // sender gap: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // stop widths: mostly short lines, plus zero, the clamp point and beyond it
   function automatic logic [6:0] pick_width();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 7'($urandom_range(1, 8));
      if (r < 80) return 7'd0;
      if (r < 88) return WIDTH_MAX;
      if (r < 94) return 7'd127;
      return 7'($urandom_range(0, 127));
   endfunction

   function automatic logic [7:0] pick_text();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30) return CH_TAB;
      if (r < 38) return CH_NL;
      return 8'($urandom_range(0, 255));
   endfunction

   // offer one text item, wait for the handshake, then log what it should give;
   // no time passes between back-to-back calls, so valid stays up without a glitch
   task automatic offer_byte(input logic [7:0] b, input int unsigned gap, input logic typed,
                             input logic [7:0] want_byte, input int unsigned want_n);
      logic [7:0]  ob;
      int unsigned n;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      n = expand_byte(b, ob);
      if (typed) queue_results(want_byte, want_n);
      else queue_results(ob, n);
   endtask

   // drop valid, drain every expected item, then wait out the settle margin
   task automatic settle();
      req_valid <= 1'b0;
      while (due_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // the enable drops before the task returns, so it never drops and rises in one step
   task automatic write_reg(input reg_index_type idx, input logic [6:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_STOP_COUNT:    cfg_count    = v[2:0];
         REG_STOP_WIDTH_A:  cfg_width[0] = v;
         REG_STOP_WIDTH_B:  cfg_width[1] = v;
         REG_STOP_WIDTH_C:  cfg_width[2] = v;
         REG_STOP_WIDTH_D:  cfg_width[3] = v;
         REG_DEFAULT_WIDTH: cfg_default  = v;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // check every accepted output item against the oldest expectation
   always @(posedge clock) begin : check_text
      text_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_text.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
               $error("item with nothing expected: out_byte %0d last %0b",
                      rsp_out_byte, rsp_last);
         end else begin
            want = due_text.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               fail_count++;
               if (fail_count <= REPORT_CAP)
                  $error("out_byte: expected %0d, got %0d", want.out_byte, rsp_out_byte);
            end
            if (rsp_last !== want.last) begin
               fail_count++;
               if (fail_count <= REPORT_CAP)
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
            end
         end
      end
   end

   // watchdog: any handshake or register write counts as progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random open and stall stretches, one long hold-off on request
   initial begin : rsp_side
      bit          pressure_done;
      int unsigned open_len;
      int unsigned hold_len;
      int unsigned r;
      pressure_done = 1'b0;
      wait (!reset);
      forever begin
         if (pressure_go && !pressure_done) begin
            // sender keeps offering, the block fills up and stalls its input
            rsp_stall <= 1'b1;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            pressure_done = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            open_len = (r < 10) ? $urandom_range(80, 200) : $urandom_range(1, 20);
            rsp_stall <= 1'b0;
            // an open stretch ends early once the long hold-off is requested
            repeat (open_len) begin
               if (pressure_go && !pressure_done) break;
               @(posedge clock);
            end
            if (pressure_go && !pressure_done) continue;
            r = $urandom_range(0, 99);
            if (r < 70) hold_len = $urandom_range(1, 2);
            else if (r < 95) hold_len = $urandom_range(3, 10);
            else hold_len = $urandom_range(20, 60);
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned seg_len;
      bit          burst;

      // reset values first: four-wide stops, no explicit list
      script = '{
         known_row(8'h41,  8'h41,    7'd1),  // plain byte opens the first stop
         known_row(CH_TAB, CH_SPACE, 7'd3),  // tab mid-interval
         known_row(CH_TAB, CH_SPACE, 7'd4),  // tab right on a stop
         known_row(8'h00,  8'h00,    7'd1),
         known_row(8'hFF,  8'hFF,    7'd1),
         known_row(CH_NL,  CH_NL,    7'd1),
         known_row(CH_TAB, CH_SPACE, 7'd4),  // tab from column zero
         known_row(CH_NL,  CH_NL,    7'd1),  // newline right after a stop advance
         // explicit list with a zero width and two over the limit
         reg_row(REG_STOP_COUNT,    7'd3),
         reg_row(REG_STOP_WIDTH_A,  7'd0),
         reg_row(REG_STOP_WIDTH_B,  7'd127),
         reg_row(REG_STOP_WIDTH_C,  7'd65),
         reg_row(REG_STOP_WIDTH_D,  7'd2),
         reg_row(REG_DEFAULT_WIDTH, 7'd1),
         byte_row(CH_TAB),
         byte_row(CH_TAB),                   // widest tab
         byte_row(CH_TAB),
         byte_row(8'h78),
         byte_row(CH_TAB),
         byte_row(CH_TAB),                   // list used up, default width
         byte_row(CH_NL),
         // count beyond the list size, default over the limit
         reg_row(REG_STOP_COUNT,    7'd7),
         reg_row(REG_STOP_WIDTH_A,  7'd64),
         reg_row(REG_STOP_WIDTH_D,  7'd5),
         reg_row(REG_DEFAULT_WIDTH, 7'd127),
         byte_row(CH_TAB),
         byte_row(CH_TAB),
         byte_row(CH_TAB),
         byte_row(CH_TAB),
         byte_row(CH_TAB),
         byte_row(CH_TAB),
         byte_row(8'h5A),
         byte_row(CH_NL)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (script[i]) begin
         if (script[i].kind == ROW_REG) begin
            settle();
            write_reg(script[i].idx, script[i].value);
         end else begin
            offer_byte(script[i].text, pick_gap(), script[i].typed,
                       script[i].want_byte, script[i].want_n);
         end
      end

      // random segments, registers rewritten between them
      settle();
      pressure_go = 1'b1;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         seg_len = $urandom_range(15, 50);
         if (seg_len > RANDOM_ITEMS - sent) seg_len = RANDOM_ITEMS - sent;
         // first segment and some others run with no sender gaps
         burst = (sent == 0) || ($urandom_range(0, 3) == 0);
         for (int unsigned k = 0; k < seg_len; k++) begin
            offer_byte(pick_text(), burst ? 0 : pick_gap(), 1'b0, 8'd0, 0);
            sent++;
         end
         settle();
         write_reg(REG_STOP_COUNT,    7'($urandom_range(0, 127)));
         write_reg(REG_STOP_WIDTH_A,  pick_width());
         write_reg(REG_STOP_WIDTH_B,  pick_width());
         write_reg(REG_STOP_WIDTH_C,  pick_width());
         write_reg(REG_STOP_WIDTH_D,  pick_width());
         write_reg(REG_DEFAULT_WIDTH, pick_width());
      end

      settle();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
